// ===== rtl/wia_pkg.sv =====
`timescale 1ns / 1ps

package wia_pkg;

    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = 4;
    localparam int FULL_BITS = 256;
    localparam int LIMB_BITS = 32;
    localparam int NUM_LIMBS = 8;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_MUL = 2'd1,
        MODE_SHL = 2'd2,
        MODE_NOP = 2'd3
    } mode_t;

    typedef struct packed {
        logic [7:0]  shift_amount;
        logic [63:0] right_w3;
        logic [63:0] right_w2;
        logic [63:0] right_w1;
        logic [63:0] right_w0;
        logic [63:0] left_w3;
        logic [63:0] left_w2;
        logic [63:0] left_w1;
        logic [63:0] left_w0;
        logic [1:0]  mode;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_w3;
        logic [63:0] result_w2;
        logic [63:0] result_w1;
        logic [63:0] result_w0;
    } out_item_t;

    // Per-stage context carried alongside the partial product
    typedef struct packed {
        logic                 valid;
        logic [1:0]           mode;
        logic [FULL_BITS-1:0] a;
        logic [FULL_BITS-1:0] b;
        logic [FULL_BITS-1:0] alt;
    } stage_ctx_t;

endpackage

// ===== rtl/wide_integer_arith_unit.sv =====
`timescale 1ns / 1ps

// done and the result come from the output register, after the input register
// and the multiply stages. Throughput: one item per cycle; busy is held low.
// The multiply sets the depth: one 32-bit left limb per stage, eight stages.
// Reset (rst_n low, asynchronous) clears all valid bits; no strobe after it
// until a new item enters. The receiver cannot stall, so no buffering exists.
module wide_integer_arith_unit #(
    parameter int OPERAND_BITS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  wia_pkg::in_item_t  in_item,
    output logic               done,
    output wia_pkg::out_item_t out_item
);
    import wia_pkg::*;

    localparam logic [FULL_BITS-1:0] OP_MASK =
        (OPERAND_BITS >= FULL_BITS) ? {FULL_BITS{1'b1}}
                                    : ((FULL_BITS'(1) << OPERAND_BITS) - FULL_BITS'(1));

    stage_ctx_t           ctx_in_reg;
    logic                 vin_reg;
    logic [7:0]           sh;
    logic [FULL_BITS-1:0] a_m;
    logic [FULL_BITS-1:0] b_m;
    logic [FULL_BITS-1:0] alt_next;

    stage_ctx_t           ctx [0:NUM_LIMBS];
    logic [FULL_BITS-1:0] acc [0:NUM_LIMBS];

    logic                 done_reg;
    logic [FULL_BITS-1:0] res_reg;
    logic [FULL_BITS-1:0] res_next;

    assign busy = 1'b0;

    // Input stage: trim operands, compute add or shift result early
    always_comb
    begin
        a_m = {in_item.left_w3, in_item.left_w2, in_item.left_w1, in_item.left_w0} & OP_MASK;
        b_m = {in_item.right_w3, in_item.right_w2, in_item.right_w1, in_item.right_w0}
              & OP_MASK;
        sh  = in_item.shift_amount;
        unique case (mode_t'(in_item.mode))
            MODE_ADD: alt_next = a_m + b_m;
            MODE_SHL: alt_next = ({24'd0, sh} < 32'(OPERAND_BITS)) ? (a_m << sh) : '0;
            MODE_MUL: alt_next = '0;
            default:  alt_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vin_reg <= 1'b0;
        end
        else
        begin
            vin_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_in_reg.valid <= 1'b0;
        ctx_in_reg.mode  <= in_item.mode;
        ctx_in_reg.a     <= a_m;
        ctx_in_reg.b     <= b_m;
        ctx_in_reg.alt   <= alt_next;
    end

    always_comb
    begin
        ctx[0]       = ctx_in_reg;
        ctx[0].valid = vin_reg;
        acc[0]       = '0;
    end

    // Multiply stages, one left limb each
    for (genvar s = 0; s < NUM_LIMBS; s++)
    begin : g_mul
        wia_mul_stage #(.STEP(s)) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctx_in  (ctx[s]),
            .acc_in  (acc[s]),
            .ctx_out (ctx[s+1]),
            .acc_out (acc[s+1])
        );
    end

    // Output select and register
    always_comb
    begin
        if (mode_t'(ctx[NUM_LIMBS].mode) == MODE_MUL)
        begin
            res_next = acc[NUM_LIMBS] & OP_MASK;
        end
        else
        begin
            res_next = ctx[NUM_LIMBS].alt & OP_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctx[NUM_LIMBS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done               = done_reg;
    assign out_item.result_w0 = res_reg[63:0];
    assign out_item.result_w1 = res_reg[127:64];
    assign out_item.result_w2 = res_reg[191:128];
    assign out_item.result_w3 = res_reg[255:192];

`ifndef ASSERT_OFF
    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        ctx[0].valid |-> ##9 done)
        else $error("item lost in pipeline");
    a_nodup: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 10))
        else $error("result without item");
`endif

endmodule

// ===== rtl/wia_mul_stage.sv =====
`timescale 1ns / 1ps

// One multiply stage: adds the partial products of left limb STEP times
// every right limb that lands in the low half, then registers.
module wia_mul_stage #(
    parameter int STEP = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  wia_pkg::stage_ctx_t     ctx_in,
    input  logic [255:0]            acc_in,
    output wia_pkg::stage_ctx_t     ctx_out,
    output logic [255:0]            acc_out
);
    import wia_pkg::*;

    logic [FULL_BITS-1:0] acc_next;
    logic [FULL_BITS-1:0] term_even;
    logic [FULL_BITS-1:0] term_odd;
    logic [LIMB_BITS-1:0] la;
    logic [FULL_BITS-1:0] acc_reg;
    stage_ctx_t           ctx_reg;
    logic                 valid_reg;

    // Row of 32x32 products of one left limb; products of even and of odd
    // right limbs do not overlap, so each set merges by OR, then two adds
    always_comb
    begin
        la        = ctx_in.a[STEP*LIMB_BITS +: LIMB_BITS];
        term_even = '0;
        term_odd  = '0;
        for (int j = 0; j < NUM_LIMBS - STEP; j++)
        begin
            if (j % 2 == 0)
            begin
                term_even = term_even
                            | ({192'd0, 64'(la * ctx_in.b[j*LIMB_BITS +: LIMB_BITS])}
                               << ((STEP + j) * LIMB_BITS));
            end
            else
            begin
                term_odd = term_odd
                           | ({192'd0, 64'(la * ctx_in.b[j*LIMB_BITS +: LIMB_BITS])}
                              << ((STEP + j) * LIMB_BITS));
            end
        end
        acc_next = acc_in + term_even + term_odd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctx_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg <= ctx_in;
        acc_reg <= acc_next;
    end

    always_comb
    begin
        ctx_out       = ctx_reg;
        ctx_out.valid = valid_reg;
        acc_out       = acc_reg;
    end

endmodule
